// ===== rtl/core/sidu_pkg.sv =====
// Shared types and constants for the sequence id unwrapper.
// No dependencies.
package sidu_pkg;

  localparam int unsigned IdW  = 64;
  localparam int unsigned CidW = 16;
  localparam int unsigned ThrW = 14;

  localparam logic [CidW-1:0] IdSpan   = 16'hFFFF;
  localparam logic [ThrW-1:0] GapReset = 14'd1500;

  typedef struct packed {
    logic            accepted;
    logic [IdW-1:0]  full_id;
  } sidu_res_t;

endpackage

// ===== rtl/core/sidu_core.sv =====
// Unwrap state and single-pass expansion of one compressed id.
// Depends on sidu_pkg.
module sidu_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [sidu_pkg::CidW-1:0]     cid_i,
  input  logic                          cfg_we_i,
  input  logic [sidu_pkg::ThrW-1:0]     cfg_data_i,
  output sidu_pkg::sidu_res_t           res_o
);
  import sidu_pkg::*;

  // base = 65535*gen - 1, basen = base + 65535; hd/hdn = base/basen - highest
  logic [ThrW-1:0] thr_q;
  logic [CidW-1:0] head_q, head_d;
  logic [IdW-1:0]  base_q, base_d, basen_q, basen_d;
  logic [IdW-1:0]  hd_q, hd_d, hdn_q, hdn_d;
  logic [IdW-1:0]  high_q, high_d;

  logic [CidW-1:0] t16, right, twot;
  logic            wrap, adv, ok, raise;
  logic            pos, neg, top_ones, top_zero, ovf, under;
  logic [IdW-1:0]  base_sel, hd_sel, id, ofs, ncid, span64;
  logic [CidW:0]   cid_t;
  logic [CidW-1:0] dlo, mag;
  logic [14:0]     sum15;

  always_comb begin
    t16   = {2'b00, thr_q};
    right = IdSpan - t16;
    twot  = {1'b0, thr_q, 1'b0};
    wrap  = (head_q > right) && (cid_i < twot);
    adv   = wrap && (cid_i > t16);

    base_sel = wrap ? basen_q : base_q;
    hd_sel   = wrap ? hdn_q : hd_q;
    id       = base_sel + IdW'(cid_i);
    cid_t    = {1'b0, cid_i} + {3'b000, thr_q};
    ofs      = hd_sel + IdW'(cid_t);
    ok       = (ofs[IdW-1:15] == '0) && (ofs[14:0] <= twot[14:0]);

    // signed id - highest, valid when ok
    dlo      = {1'b0, ofs[14:0]} - t16;
    neg      = dlo[CidW-1];
    pos      = !neg && (dlo != '0);
    mag      = neg ? (CidW'(0) - dlo) : dlo;
    top_ones = &high_q[IdW-1:14];
    top_zero = ~|high_q[IdW-1:14];
    sum15    = {1'b0, high_q[13:0]} + {1'b0, mag[13:0]};
    ovf      = top_ones && sum15[14];
    under    = top_zero && (high_q[13:0] < mag[13:0]);
    raise    = pos ? !ovf : (neg && under);

    ncid   = IdW'(0) - IdW'(cid_i);
    span64 = IdW'(IdSpan);

    head_d  = head_q;
    base_d  = base_q;
    basen_d = basen_q;
    hd_d    = hd_q;
    hdn_d   = hdn_q;
    high_d  = high_q;
    if (ok) begin
      head_d = (adv || (cid_i > head_q)) ? cid_i : head_q;
      if (raise) high_d = id;
      if (adv) begin
        base_d  = basen_q;
        basen_d = basen_q + span64;
      end
      if (adv && raise) begin
        hd_d  = ncid;
        hdn_d = span64 + ncid;
      end else if (adv) begin
        hd_d  = hdn_q;
        hdn_d = hdn_q + span64;
      end else if (raise) begin
        hd_d  = wrap ? (ncid - span64) : ncid;
        hdn_d = wrap ? ncid : (span64 + ncid);
      end
    end

    res_o.accepted = ok;
    res_o.full_id  = ok ? id : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= GapReset;
      head_q  <= '0;
      base_q  <= '1;
      basen_q <= IdW'(IdSpan) - IdW'(1);
      hd_q    <= '1;
      hdn_q   <= IdW'(IdSpan) - IdW'(1);
      high_q  <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (step_i) begin
        head_q  <= head_d;
        base_q  <= base_d;
        basen_q <= basen_d;
        hd_q    <= hd_d;
        hdn_q   <= hdn_d;
        high_q  <= high_d;
      end
    end
  end

endmodule

// ===== rtl/core/sequence_id_unwrapper.sv =====
// Top level: request register, unwrap core, result register.
// Depends on sidu_pkg and sidu_core.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  cfg     | cfg_valid_i/cfg_ready_o, gap_threshold_i  | in
//  in      | in_valid_i/in_ready_o, compressed_id_i    | in
//  out     | out_valid_o/out_ready_i, accepted_o,      | out
//          | full_id_o                                 |
//
// One request per cycle sustained while out_ready_i is high; a request passes the request register,
// then the core's single pass into the result register.
// Throughput is set by the state update in sidu_core, done in one pass per request.
// Reset leaves gap_threshold at 1500, head and highest id at zero, and the bases at generation zero.
// A stalled result holds; the request register keeps filling until both
// stages are full. cfg_ready_o is always high.
module sequence_id_unwrapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sidu_pkg::ThrW-1:0]     gap_threshold_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sidu_pkg::CidW-1:0]     compressed_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic [sidu_pkg::IdW-1:0]      full_id_o
);
  import sidu_pkg::*;

  logic            in_vld_q, out_vld_q, fwd;
  logic [CidW-1:0] cid_q;
  sidu_res_t       res, res_q;

  assign fwd         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fwd;
  assign cfg_ready_o = 1'b1;

  sidu_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fwd),
    .cid_i      (cid_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (gap_threshold_i),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (fwd) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) cid_q <= compressed_id_i;
    if (fwd) res_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign accepted_o  = res_q.accepted;
  assign full_id_o   = res_q.full_id;

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("request side stalled without result backpressure");

  a_fwd_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd |=> out_valid_o)
    else $error("processed request produced no result");

  a_reject_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (full_id_o == '0))
    else $error("rejected result carries a nonzero id");

endmodule

// ===== tb/sequence_id_unwrapper_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sequence_id_unwrapper: a directed request table, then random phases of
// in-order id streams with jitter and noise, each result checked against the table or a local predictor.
// Depends on sidu_pkg and the sequence_id_unwrapper RTL.
module sequence_id_unwrapper_tb;
  import sidu_pkg::*;

  typedef enum logic {ROW_ID, ROW_THR} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [CidW-1:0]  value;
    bit               typed;
    sidu_res_t        res;
  } row_t;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned PhaseItems  = 110;
  localparam int unsigned MaxPrints   = 40;
  localparam int          Span        = int'(IdSpan);

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [ThrW-1:0]  gap_threshold_i = '0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [CidW-1:0]  compressed_id_i = '0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic             accepted_o;
  logic [IdW-1:0]   full_id_o;

  // predictor state
  logic [CidW-1:0]  head_q;
  logic [IdW-1:0]   gen_q;
  logic [IdW-1:0]   top_q;
  logic [ThrW-1:0]  thr_q;

  sidu_res_t        id_q[$];
  row_t             rows[$];
  int unsigned      errs        = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      in_odds     = 0;
  int unsigned      out_odds    = 0;
  int unsigned      out_hold    = 0;

  sequence_id_unwrapper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .gap_threshold_i (gap_threshold_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .compressed_id_i (compressed_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .full_id_o       (full_id_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (errs < MaxPrints) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    errs++;
  endtask

  function automatic sidu_res_t unwrap_id(input logic [CidW-1:0] cid);
    logic [IdW-1:0] t;
    logic [IdW-1:0] g;
    logic [IdW-1:0] id;
    logic [IdW-1:0] ofs;
    bit             adv;
    sidu_res_t      r;
    t   = IdW'(thr_q);
    g   = gen_q;
    adv = 1'b0;
    if (IdW'(head_q) > IdW'(IdSpan) - t && IdW'(cid) < t + t) begin
      g   = g + 64'd1;
      adv = IdW'(cid) > t;
    end
    id  = IdW'(cid) + IdW'(IdSpan) * g - 64'd1;
    ofs = id - top_q + t;
    r.accepted = 1'b0;
    r.full_id  = '0;
    if (ofs <= t + t) begin
      if (adv) begin
        gen_q  = gen_q + 64'd1;
        head_q = cid;
      end
      if (cid > head_q) head_q = cid;
      if (id > top_q) top_q = id;
      r.accepted = 1'b1;
      r.full_id  = id;
    end
    return r;
  endfunction

  // compressed id that maps to the highest id seen
  function automatic int top_cid();
    int c;
    c = int'((top_q + 64'd1) % IdW'(IdSpan));
    return (c == 0) ? Span : c;
  endfunction

  function automatic logic [CidW-1:0] pick_id(input bit fwd);
    int c;
    int t;
    int step;
    int r;
    c = top_cid();
    t = int'(thr_q);
    r = fwd ? 0 : int'($urandom_range(0, 99));
    if (r < 55) begin
      step = (t >= 2) ? int'($urandom_range(1, t - 1)) : t;
    end else if (r < 70) begin
      step = int'($urandom_range(0, (t < 3) ? t : 3));
    end else if (r < 82) begin
      step = -int'($urandom_range(1, t + 1));
    end else if (r < 90) begin
      step = ($urandom_range(0, 1) ? 1 : -1) * (t + int'($urandom_range(0, 1)));
    end else begin
      c = int'($urandom_range(0, Span));
      // an all-ones id accepted in generation zero would pin the window
      if (c == 0 && gen_q == '0) c = 1;
      return c[CidW-1:0];
    end
    c = c + step;
    if (c > Span) c = c - Span;
    else if (c < 1) c = c + Span;
    return c[CidW-1:0];
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [CidW-1:0] value,
                         input bit typed, input logic acc, input logic [IdW-1:0] id);
    row_t r;
    r.kind         = kind;
    r.value        = value;
    r.typed        = typed;
    r.res.accepted = acc;
    r.res.full_id  = id;
    rows.push_back(r);
  endtask

  task automatic send_id(input logic [CidW-1:0] cid, input bit typed, input sidu_res_t res);
    sidu_res_t r;
    if (in_odds != 0 && $urandom_range(1, in_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    compressed_id_i <= cid;
    do @(posedge clk_i); while (!in_ready_o);
    r = unwrap_id(cid);
    id_q.push_back(typed ? res : r);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] v);
    in_valid_i <= 1'b0;
    while (id_q.size() != 0) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    gap_threshold_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_q = v;
  endtask

  // push a half-finished wrap through so the next threshold starts clean
  task automatic settle_wrap();
    int unsigned n;
    n = 0;
    while (thr_q >= 2 && top_cid() < int'(head_q) && n < 60) begin
      send_id(pick_id(1'b1), 1'b0, '0);
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_odds == 0) begin
      out_ready_i <= 1'b1;
    end else if (out_hold != 0) begin
      out_ready_i <= 1'b0;
      out_hold    <= out_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(1, out_odds) == 1) out_hold <= $urandom_range(1, 18);
    end
  end

  always @(posedge clk_i) begin : check_results
    sidu_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (id_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result accepted=%0b full_id=%h",
                                  accepted_o, full_id_o));
      end else begin
        want = id_q.pop_front();
        if (accepted_o !== want.accepted) begin
          report_mismatch($sformatf("accepted %0b, want %0b", accepted_o, want.accepted));
        end
        if (full_id_o !== want.full_id) begin
          report_mismatch($sformatf("full_id %h, want %h", full_id_o, want.full_id));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    logic [ThrW-1:0] plan[$];
    int unsigned     k;
    int unsigned     p;
    head_q = '0;
    gen_q  = '0;
    top_q  = '0;
    thr_q  = GapReset;

    // state from reset, window edges, id zero, largest id
    add_row(ROW_ID, 16'd1, 1'b1, 1'b1, 64'd0);
    add_row(ROW_ID, 16'd1501, 1'b1, 1'b1, 64'd1500);
    add_row(ROW_ID, 16'd3002, 1'b1, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd0, 1'b1, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd3001, 1'b1, 1'b1, 64'd3000);
    add_row(ROW_ID, 16'd2000, 1'b1, 1'b1, 64'd1999);
    add_row(ROW_ID, 16'd65535, 1'b1, 1'b0, 64'd0);
    // widest window, through one generation wrap
    add_row(ROW_THR, 16'd16383, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd19000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd35000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd51000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd65535, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd100, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd16000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd20000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd0, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd30000, 1'b0, 1'b0, 64'd0);
    // zero threshold: only the highest id itself passes
    add_row(ROW_THR, 16'd0, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd30000, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd30001, 1'b1, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd29999, 1'b1, 1'b0, 64'd0);
    add_row(ROW_THR, 16'd1, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd30001, 1'b0, 1'b0, 64'd0);
    add_row(ROW_ID, 16'd30003, 1'b1, 1'b0, 64'd0);

    plan = '{14'd16383, 14'd0, 14'd1, 14'd0, 14'd0, 14'd0,
             14'd0, 14'd16383, 14'd0, 14'd2, 14'd0, 14'd0};
    foreach (plan[i]) begin
      if (i != 0 && i != 2 && i != 5 && i != 7 && i != 9) begin
        plan[i] = ($urandom_range(0, 3) == 0) ? ThrW'($urandom_range(2, 300))
                                              : ThrW'($urandom_range(2, 16383));
      end
    end

    in_odds  = 4;
    out_odds = 5;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_THR) begin
        write_threshold(ThrW'(rows[i].value));
      end else begin
        send_id(rows[i].value, rows[i].typed, rows[i].res);
      end
    end

    for (p = 0; p < plan.size(); p++) begin
      write_threshold(plan[p]);
      if (p == plan.size() - 1) begin
        in_odds  = 0;
        out_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_odds = 0;
          1:       in_odds = 3;
          default: in_odds = 8;
        endcase
        case ($urandom_range(0, 2))
          0:       out_odds = 0;
          1:       out_odds = 3;
          default: out_odds = 8;
        endcase
      end
      for (k = 0; k < PhaseItems; k++) begin
        send_id(pick_id(1'b0), 1'b0, '0);
      end
      settle_wrap();
    end

    in_valid_i <= 1'b0;
    while (id_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sidu_pkg.sv
rtl/core/sidu_core.sv
rtl/core/sequence_id_unwrapper.sv
tb/sequence_id_unwrapper_tb.sv
